@@ rtl/core/hrgb_pkg.sv @@
// Shared types and constants for the HSL to RGB converter.
// No dependencies; imported by every module of the converter.
`timescale 1ns / 1ps

package hrgb_pkg;

  // Port widths of the input fractions and the output colour channels.
  localparam int IN_W   = 13;
  localparam int OUT_W  = 8;
  localparam int SECT_W = 3;

  typedef logic [SECT_W-1:0] sector_t;

  // The six 60-degree hue sectors.
  localparam sector_t SECT_0 = 3'd0;
  localparam sector_t SECT_1 = 3'd1;
  localparam sector_t SECT_2 = 3'd2;
  localparam sector_t SECT_3 = 3'd3;
  localparam sector_t SECT_4 = 3'd4;
  localparam sector_t SECT_5 = 3'd5;

endpackage

@@ rtl/core/hsl_to_rgb_converter_unit.sv @@
// Top level of the HSL to RGB converter: three pipeline sections in a chain.
// Depends on hrgb_pkg, hrgb_prep, hrgb_mul and hrgb_mix.
//
//   Channel   Ports                                   Direction
//   input     in_valid/in_ready, in_hue,               sink
//             in_saturation, in_lightness
//   result    out_valid/out_ready, out_red,            source
//             out_green, out_blue
//
// One request is taken every clock cycle unless a stall on the result side has
// filled every stage. There are five register stages: input preparation, the
// two multiplier stages, sector placement and the wide times-255 stage at the
// end. Reset empties every stage. A stall on the result side holds each full
// stage; empty stages ahead of it still fill, so requests keep flowing until
// all five stages hold an item.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hrgb_pkg::IN_W-1:0]  in_hue,
  input  logic [hrgb_pkg::IN_W-1:0]  in_saturation,
  input  logic [hrgb_pkg::IN_W-1:0]  in_lightness,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hrgb_pkg::OUT_W-1:0] out_red,
  output logic [hrgb_pkg::OUT_W-1:0] out_green,
  output logic [hrgb_pkg::OUT_W-1:0] out_blue
);
  import hrgb_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int DEPTH = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic         p_valid, p_ready;
  logic [F:0]   p_sat, p_light, p_om, p_od;
  sector_t      p_sector;

  logic         m_valid, m_ready;
  logic [2*F:0] m_chroma;
  logic [3*F:0] m_cx;
  logic [2*F+1:0] m_mvh;
  sector_t      m_sector;

  hrgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_lightness (in_lightness),
    .out_valid    (p_valid),
    .out_ready    (p_ready),
    .out_sat      (p_sat),
    .out_light    (p_light),
    .out_om       (p_om),
    .out_od       (p_od),
    .out_sector   (p_sector)
  );

  hrgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_sat    (p_sat),
    .in_light  (p_light),
    .in_om     (p_om),
    .in_od     (p_od),
    .in_sector (p_sector),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_chroma(m_chroma),
    .out_cx    (m_cx),
    .out_mvh   (m_mvh),
    .out_sector(m_sector)
  );

  hrgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (m_valid),
    .in_ready (m_ready),
    .in_chroma(m_chroma),
    .in_cx    (m_cx),
    .in_mvh   (m_mvh),
    .in_sector(m_sector),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue)
  );

  // Count of requests inside the pipeline, kept for the checks below.
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_r, inflight_nxt;

  assign in_acc       = in_valid && in_ready;
  assign out_acc      = out_valid && out_ready;
  assign inflight_nxt = inflight_r + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result presented with no request in flight");

  a_bubble_fill: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r < CNT_W'(DEPTH) |-> in_ready)
    else $error("input stalled while a pipeline stage is empty");

endmodule

@@ rtl/core/hrgb_prep.sv @@
// First pipeline stage: input clamping, |2l-1|, hue sector and sector offset.
// Depends on hrgb_pkg.
`timescale 1ns / 1ps

module hrgb_prep #(
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hrgb_pkg::IN_W-1:0]   in_hue,
  input  logic [hrgb_pkg::IN_W-1:0]   in_saturation,
  input  logic [hrgb_pkg::IN_W-1:0]   in_lightness,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [FRAC_BITS:0]          out_sat,
  output logic [FRAC_BITS:0]          out_light,
  output logic [FRAC_BITS:0]          out_om,
  output logic [FRAC_BITS:0]          out_od,
  output hrgb_pkg::sector_t           out_sector
);
  import hrgb_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int HW = (IN_W > F) ? IN_W : F;
  localparam int CW = HW + 1;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic [HW-1:0] hue_x;
  logic [F-1:0]  h;
  logic [CW-1:0] sat_w, light_w, one_w;
  logic [F+1:0]  twol, one2, dist2;
  logic [F+2:0]  h6;
  logic [F:0]    f, d;

  logic [F:0]    sat_nxt, light_nxt, om_nxt, od_nxt;
  sector_t       sector_nxt;

  logic          v_r;
  logic [F:0]    sat_r, light_r, om_r, od_r;
  sector_t       sector_r;
  logic          en;

  always_comb begin
    // Hue wraps modulo one full turn, so a hue of exactly 1.0 lands in sector 0.
    hue_x = HW'(in_hue);
    h     = hue_x[F-1:0];

    sat_w     = CW'(in_saturation);
    light_w   = CW'(in_lightness);
    one_w     = CW'(ONE);
    sat_nxt   = (sat_w > one_w) ? ONE : sat_w[F:0];
    light_nxt = (light_w > one_w) ? ONE : light_w[F:0];

    twol   = {light_nxt, 1'b0};
    one2   = (F+2)'(ONE);
    dist2  = (twol >= one2) ? (twol - one2) : (one2 - twol);
    om_nxt = ONE - dist2[F:0];

    h6         = (F+3)'({h, 2'b00}) + (F+3)'({h, 1'b0});
    sector_nxt = h6[F+2:F];
    f          = h6[F:0];
    d          = (f >= ONE) ? (f - ONE) : (ONE - f);
    od_nxt     = ONE - d;
  end

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      sat_r    <= sat_nxt;
      light_r  <= light_nxt;
      om_r     <= om_nxt;
      od_r     <= od_nxt;
      sector_r <= sector_nxt;
    end
  end

  assign out_valid  = v_r;
  assign out_sat    = sat_r;
  assign out_light  = light_r;
  assign out_om     = om_r;
  assign out_od     = od_r;
  assign out_sector = sector_r;

endmodule

@@ rtl/core/hrgb_mul.sv @@
// Two multiplier stages: chroma = (1-|2l-1|)*s, then chroma times the x weight.
// Also forms the lightness offset m. Depends on hrgb_pkg.
`timescale 1ns / 1ps

module hrgb_mul #(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FRAC_BITS:0]    in_sat,
  input  logic [FRAC_BITS:0]    in_light,
  input  logic [FRAC_BITS:0]    in_om,
  input  logic [FRAC_BITS:0]    in_od,
  input  hrgb_pkg::sector_t     in_sector,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2*FRAC_BITS:0]  out_chroma,
  output logic [3*FRAC_BITS:0]  out_cx,
  output logic [2*FRAC_BITS+1:0] out_mvh,
  output hrgb_pkg::sector_t     out_sector
);
  import hrgb_pkg::*;

  localparam int F = FRAC_BITS;

  // Stage A: chroma, scaled by ONE^2.
  logic [2*F+1:0] chroma_full;
  logic [2*F:0]   chroma_nxt;
  logic           va_r;
  logic [2*F:0]   chroma_a_r;
  logic [F:0]     light_a_r, od_a_r;
  sector_t        sect_a_r;
  logic           en_a;

  // Stage B: chroma*(1-d) scaled by ONE^3 and m scaled by 2*ONE^2.
  logic [3*F+2:0] cx_full;
  logic [3*F:0]   cx_nxt;
  logic [2*F+1:0] mvh_nxt;
  logic           vb_r;
  logic [2*F:0]   chroma_b_r;
  logic [3*F:0]   cx_b_r;
  logic [2*F+1:0] mvh_b_r;
  sector_t        sect_b_r;
  logic           en_b;

  assign chroma_full = (2*F+2)'(in_om) * (2*F+2)'(in_sat);
  assign chroma_nxt  = chroma_full[2*F:0];

  assign cx_full = (3*F+3)'(chroma_a_r) * (3*F+3)'(od_a_r);
  assign cx_nxt  = cx_full[3*F:0];
  // Chroma never exceeds 2*l*ONE, so the difference stays non-negative.
  assign mvh_nxt = {light_a_r, 1'b0, {F{1'b0}}} - (2*F+2)'(chroma_a_r);

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      chroma_a_r <= chroma_nxt;
      light_a_r  <= in_light;
      od_a_r     <= in_od;
      sect_a_r   <= in_sector;
    end
    if (en_b && va_r) begin
      chroma_b_r <= chroma_a_r;
      cx_b_r     <= cx_nxt;
      mvh_b_r    <= mvh_nxt;
      sect_b_r   <= sect_a_r;
    end
  end

  assign out_valid  = vb_r;
  assign out_chroma = chroma_b_r;
  assign out_cx     = cx_b_r;
  assign out_mvh    = mvh_b_r;
  assign out_sector = sect_b_r;

endmodule

@@ rtl/core/hrgb_mix.sv @@
// Two final stages: sector placement of c and x plus m, then scaling by 255.
// Depends on hrgb_pkg.
`timescale 1ns / 1ps

module hrgb_mix #(
  parameter int FRAC_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2*FRAC_BITS:0]     in_chroma,
  input  logic [3*FRAC_BITS:0]     in_cx,
  input  logic [2*FRAC_BITS+1:0]   in_mvh,
  input  hrgb_pkg::sector_t        in_sector,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [hrgb_pkg::OUT_W-1:0] out_red,
  output logic [hrgb_pkg::OUT_W-1:0] out_green,
  output logic [hrgb_pkg::OUT_W-1:0] out_blue
);
  import hrgb_pkg::*;

  localparam int F  = FRAC_BITS;
  // Channel totals are scaled by 2*ONE^3 and never exceed that value.
  localparam int TW = 3*F + 2;
  localparam int PW = TW + 8;
  localparam int SH = 3*F + 1;

  localparam logic [1:0] SEL_C = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  function automatic logic [5:0] sect_sel(sector_t s);
    logic [5:0] r;
    case (s)
      SECT_0:  r = {SEL_C, SEL_X, SEL_Z};
      SECT_1:  r = {SEL_X, SEL_C, SEL_Z};
      SECT_2:  r = {SEL_Z, SEL_C, SEL_X};
      SECT_3:  r = {SEL_Z, SEL_X, SEL_C};
      SECT_4:  r = {SEL_X, SEL_Z, SEL_C};
      SECT_5:  r = {SEL_C, SEL_Z, SEL_X};
      default: r = {SEL_C, SEL_Z, SEL_X};
    endcase
    return r;
  endfunction

  function automatic logic [TW-1:0] pick(logic [1:0] code, logic [TW-1:0] tc,
                                         logic [TW-1:0] tx, logic [TW-1:0] tz);
    logic [TW-1:0] r;
    case (code)
      SEL_C:   r = tc;
      SEL_X:   r = tx;
      default: r = tz;
    endcase
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] scale(logic [TW-1:0] t);
    logic [PW-1:0] p;
    logic [8:0]    q;
    // t*255 as (t << 8) - t; the common denominator is a power of two.
    p = {t, 8'b0} - PW'(t);
    q = p[PW-1:SH];
    return q[8] ? {OUT_W{1'b1}} : q[OUT_W-1:0];
  endfunction

  logic [2*F+2:0] csum;
  logic [TW-1:0]  tc, tx, tz;
  logic [5:0]     sel;
  logic [TW-1:0]  tr_nxt, tg_nxt, tb_nxt;
  logic           va_r;
  logic [TW-1:0]  tr_r, tg_r, tb_r;
  logic           en_a;

  logic [OUT_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic             vb_r;
  logic [OUT_W-1:0] red_r, green_r, blue_r;
  logic             en_b;

  always_comb begin
    csum   = (2*F+3)'({in_chroma, 1'b0}) + (2*F+3)'(in_mvh);
    tz     = TW'(in_mvh) << F;
    tc     = TW'(csum) << F;
    tx     = TW'({in_cx, 1'b0}) + tz;
    sel    = sect_sel(in_sector);
    tr_nxt = pick(sel[5:4], tc, tx, tz);
    tg_nxt = pick(sel[3:2], tc, tx, tz);
    tb_nxt = pick(sel[1:0], tc, tx, tz);
  end

  assign red_nxt   = scale(tr_r);
  assign green_nxt = scale(tg_r);
  assign blue_nxt  = scale(tb_r);

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      tr_r <= tr_nxt;
      tg_r <= tg_nxt;
      tb_r <= tb_nxt;
    end
    if (en_b && va_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule
